// ===== hw/rtl/ctd_pkg.sv =====
package ctd_pkg;

  localparam int unsigned MAX_LINE  = 32768;
  localparam int unsigned MAX_CHUNK = 4194304;

  localparam int unsigned SIZE_W = 23;
  localparam int unsigned LINE_W = 16;

  // result kinds (tuser)
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_CHUNK   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_LINE    = 2'd1;
  localparam logic [1:0] ERR_SIZE    = 2'd2;
  localparam logic [1:0] ERR_TRAILER = 2'd3;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic [1:0] error_code;
  } result_t;

endpackage

// ===== hw/rtl/chunked_transfer_dechunker_core.sv =====
// Chunked transfer decoder. Takes one byte per clock on the slave stream,
// unless the skid is full, and gives at most one word per byte on the master
// stream: a single state update stands between the input and the output
// register, and a one-word skid stage behind the output register keeps
// input ready while a result waits. With chunked_enable clear, bytes pass
// through; with it set, size lines are parsed, payload bytes are streamed
// out as they arrive, and a chunk complete, stream end or error word marks
// the framing. After stream end or an error the block drops all further
// bytes until reset. Write chunked_enable only while the stream is idle.
module chunked_transfer_dechunker_core
  import ctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // chunked_enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload, [9:8] error_code, zeros
  output logic [1:0]  m_axis_tuser    // kind
);

  localparam logic [2:0] PH_LEAD     = 3'd0;
  localparam logic [2:0] PH_DIGITS   = 3'd1;
  localparam logic [2:0] PH_TRAIL_WS = 3'd2;
  localparam logic [2:0] PH_EXT      = 3'd3;
  localparam logic [2:0] PH_PAYLOAD  = 3'd4;
  localparam logic [2:0] PH_TRAILER  = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;
  localparam logic [2:0] PH_ERROR    = 3'd7;

  logic                chunked_enable;
  logic [2:0]          phase, phase_next;
  logic [SIZE_W-1:0]   size_acc, size_acc_next;
  logic                size_invalid, size_invalid_next;
  logic                digit_seen, digit_seen_next;
  logic [LINE_W-1:0]   line_len, line_len_next;
  logic                last_was_cr, last_was_cr_next;
  logic [SIZE_W-1:0]   bytes_rem, bytes_rem_next;
  logic                first_trailer_ok, first_trailer_ok_next;

  logic                has_result;
  result_t             res;

  logic                out_valid, skid_valid;
  result_t             out_data, skid_data;

  logic                accept, pop;
  logic [7:0]          b;
  logic                is_space, is_hex;
  logic [3:0]          hex_val;
  logic [SIZE_W+3:0]   acc_shift;
  logic [SIZE_W-1:0]   rem_dec;

  assign b      = s_axis_tdata;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = out_valid && m_axis_tready;

  assign is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign acc_shift = {size_acc, 4'd0} + {{SIZE_W{1'b0}}, hex_val};
  assign rem_dec   = bytes_rem - SIZE_W'(1);

  always_comb begin
    phase_next            = phase;
    size_acc_next         = size_acc;
    size_invalid_next     = size_invalid;
    digit_seen_next       = digit_seen;
    line_len_next         = line_len;
    last_was_cr_next      = last_was_cr;
    bytes_rem_next        = bytes_rem;
    first_trailer_ok_next = first_trailer_ok;
    has_result            = 1'b0;
    res                   = '{kind: KIND_PAYLOAD, payload: 8'd0, error_code: ERR_NONE};

    if (phase == PH_DONE || phase == PH_ERROR) begin
      has_result = 1'b0;
    end else if (!chunked_enable) begin
      has_result  = 1'b1;
      res.payload = b;
    end else begin
      case (phase)
        PH_LEAD, PH_DIGITS, PH_TRAIL_WS, PH_EXT: begin
          if (b == CH_LF && last_was_cr) begin
            size_acc_next     = '0;
            size_invalid_next = 1'b0;
            digit_seen_next   = 1'b0;
            line_len_next     = '0;
            last_was_cr_next  = 1'b0;
            if (size_invalid || !digit_seen) begin
              phase_next     = PH_ERROR;
              has_result     = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SIZE;
            end else if (size_acc == '0) begin
              phase_next = PH_DONE;
              has_result = 1'b1;
              res.kind   = KIND_END;
            end else begin
              bytes_rem_next = size_acc;
              phase_next     = PH_PAYLOAD;
            end
          end else if (line_len >= LINE_W'(MAX_LINE)) begin
            phase_next     = PH_ERROR;
            has_result     = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_LINE;
          end else begin
            line_len_next    = line_len + LINE_W'(1);
            last_was_cr_next = (b == CH_CR);
            if (phase == PH_EXT) begin
              phase_next = PH_EXT;
            end else if (b == CH_SEMI) begin
              phase_next = PH_EXT;
            end else if (is_space) begin
              if (phase == PH_DIGITS) begin
                phase_next = PH_TRAIL_WS;
              end
            end else if (is_hex && phase != PH_TRAIL_WS) begin
              phase_next      = PH_DIGITS;
              digit_seen_next = 1'b1;
              if (acc_shift > (SIZE_W+4)'(MAX_CHUNK)) begin
                size_invalid_next = 1'b1;
              end else begin
                size_acc_next = acc_shift[SIZE_W-1:0];
              end
            end else begin
              size_invalid_next = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_rem_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next            = PH_TRAILER;
            first_trailer_ok_next = 1'b0;
          end
          has_result  = 1'b1;
          res.payload = b;
        end
        PH_TRAILER: begin
          if (!first_trailer_ok) begin
            if (b != CH_CR) begin
              phase_next     = PH_ERROR;
              has_result     = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_TRAILER;
            end else begin
              first_trailer_ok_next = 1'b1;
            end
          end else if (b != CH_LF) begin
            phase_next     = PH_ERROR;
            has_result     = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRAILER;
          end else begin
            first_trailer_ok_next = 1'b0;
            phase_next            = PH_LEAD;
            size_acc_next         = '0;
            size_invalid_next     = 1'b0;
            digit_seen_next       = 1'b0;
            line_len_next         = '0;
            last_was_cr_next      = 1'b0;
            has_result            = 1'b1;
            res.kind              = KIND_CHUNK;
          end
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_enable   <= 1'b0;
      phase            <= PH_LEAD;
      size_acc         <= '0;
      size_invalid     <= 1'b0;
      digit_seen       <= 1'b0;
      line_len         <= '0;
      last_was_cr      <= 1'b0;
      bytes_rem        <= '0;
      first_trailer_ok <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chunked_enable <= cfg_wr_data;
      end
      if (accept) begin
        phase            <= phase_next;
        size_acc         <= size_acc_next;
        size_invalid     <= size_invalid_next;
        digit_seen       <= digit_seen_next;
        line_len         <= line_len_next;
        last_was_cr      <= last_was_cr_next;
        bytes_rem        <= bytes_rem_next;
        first_trailer_ok <= first_trailer_ok_next;
      end
    end
  end

  // output word register with a one-word skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && has_result;
      end
    end else if (accept && has_result) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (out_valid && !pop && !skid_valid) begin
      skid_data <= res;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_data.kind;
  assign m_axis_tdata  = {6'd0, out_data.error_code, out_data.payload};

endmodule

// ===== hw/rtl/ctd_checker.sv =====
module ctd_checker
  import ctd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // error code present exactly on error words
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tuser == KIND_ERROR) == (m_axis_tdata[9:8] != ERR_NONE)))
    else $error("error code does not match kind");

  // only payload words carry a byte
  a_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |-> m_axis_tdata[7:0] == 8'd0)
    else $error("non-payload word carries a byte");

  // stream end or error is the last word
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready &&
      (m_axis_tuser == KIND_ERROR || m_axis_tuser == KIND_END) |=> !m_axis_tvalid)
    else $error("word after stream end or error");

endmodule

bind chunked_transfer_dechunker_core ctd_checker u_ctd_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ctd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam logic [7:0]  CH_SPACE      = 8'h20;

  typedef enum logic [3:0] {
    ST_LEAD, ST_DIGITS, ST_TRAIL, ST_EXT, ST_PAYLOAD, ST_TRAILER, ST_DONE, ST_FAILED
  } parse_state_t;

  typedef enum int {
    CLOSE_END, CLOSE_LONG_LINE, CLOSE_NO_DIGIT, CLOSE_BAD_CHAR, CLOSE_OVERSIZE,
    CLOSE_BAD_TRAILER
  } close_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic        cfg_wr_data   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  chunked_transfer_dechunker_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as predicted
  logic         chunk_mode    = 1'b0;
  parse_state_t ph            = ST_LEAD;
  logic [22:0]  size_acc      = '0;
  logic         size_bad      = 1'b0;
  logic         have_digit    = 1'b0;
  logic [15:0]  line_len      = '0;
  logic         cr_before     = 1'b0;
  logic [22:0]  left_bytes    = '0;
  logic         trailer_cr_ok = 1'b0;

  result_t      pending_words[$];
  logic [7:0]   frame_q[$];

  int unsigned  src_idle_pct  = 6;
  int unsigned  sink_idle_pct = 62;
  int unsigned  sink_hold     = 0;
  int unsigned  items_sent    = 0;
  int unsigned  mismatches    = 0;

  function automatic void expect_word(input logic [1:0] k, input logic [7:0] p,
                                      input logic [1:0] e);
    result_t w;
    w.kind       = k;
    w.payload    = p;
    w.error_code = e;
    pending_words.push_back(w);
  endfunction

  function automatic void fail_with(input logic [1:0] code);
    ph = ST_FAILED;
    expect_word(KIND_ERROR, 8'h00, code);
  endfunction

  function automatic void clear_size_line();
    size_acc   = '0;
    size_bad   = 1'b0;
    have_digit = 1'b0;
    line_len   = '0;
    cr_before  = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [31:0] grown;
    int          nib;
    if (ph == ST_DONE || ph == ST_FAILED) return;
    if (!chunk_mode) begin
      expect_word(KIND_PAYLOAD, b, ERR_NONE);
      return;
    end
    case (ph)
      ST_PAYLOAD: begin
        left_bytes = left_bytes - 1'b1;
        if (left_bytes == 0) begin
          ph = ST_TRAILER;
          trailer_cr_ok = 1'b0;
        end
        expect_word(KIND_PAYLOAD, b, ERR_NONE);
      end
      ST_TRAILER: begin
        if (!trailer_cr_ok) begin
          if (b != CH_CR) fail_with(ERR_TRAILER);
          else trailer_cr_ok = 1'b1;
        end else if (b != CH_LF) begin
          fail_with(ERR_TRAILER);
        end else begin
          trailer_cr_ok = 1'b0;
          ph = ST_LEAD;
          clear_size_line();
          expect_word(KIND_CHUNK, 8'h00, ERR_NONE);
        end
      end
      default: begin
        // size line; CR LF ends it before the length limit is looked at
        if (b == CH_LF && cr_before) begin
          if (size_bad || !have_digit) begin
            fail_with(ERR_SIZE);
          end else if (size_acc == 0) begin
            ph = ST_DONE;
            expect_word(KIND_END, 8'h00, ERR_NONE);
          end else begin
            left_bytes = size_acc;
            ph = ST_PAYLOAD;
          end
          clear_size_line();
        end else if (line_len >= MAX_LINE) begin
          fail_with(ERR_LINE);
        end else begin
          line_len  = line_len + 1'b1;
          cr_before = (b == CH_CR);
          if (ph != ST_EXT) begin
            if (b == CH_SEMI) begin
              ph = ST_EXT;
            end else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) begin
              if (ph == ST_DIGITS) ph = ST_TRAIL;
            end else begin
              if (b >= "0" && b <= "9") nib = b - "0";
              else if (b >= "a" && b <= "f") nib = b - "a" + 10;
              else if (b >= "A" && b <= "F") nib = b - "A" + 10;
              else nib = -1;
              if (nib >= 0 && ph != ST_TRAIL) begin
                ph = ST_DIGITS;
                have_digit = 1'b1;
                grown = (32'(size_acc) << 4) + nib;
                // an oversized value keeps the old accumulator
                if (grown > MAX_CHUNK) size_bad = 1'b1;
                else size_acc = grown[22:0];
              end else begin
                size_bad = 1'b1;
              end
            end
          end
        end
      end
    endcase
  endfunction

  // receiver: random stalls, or a forced hold while sink_hold counts down
  always @(negedge clk) begin
    if (sink_hold != 0) begin
      sink_hold = sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : word_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d tdata %h, expected none",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tuser !== want.kind ||
            m_axis_tdata !== {6'd0, want.error_code, want.payload}) begin
          $display("%0t: expected kind %0d payload %h code %0d, got kind %0d tdata %h",
                   $time, want.kind, want.payload, want.error_code,
                   m_axis_tuser, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    chunk_mode = v;
  endtask

  // parse state must survive a pass-through burst
  task automatic detour_passthrough(input int unsigned n);
    drain_block();
    write_mode(1'b0);
    repeat (n) send_byte(8'($urandom_range(255)));
    drain_block();
    write_mode(1'b1);
  endtask

  task automatic send_frame(input int detour_at);
    int i;
    for (i = 0; i < frame_q.size(); i++) begin
      if (i == detour_at) detour_passthrough($urandom_range(1, 12));
      send_byte(frame_q[i]);
    end
  endtask

  function automatic logic [7:0] ws_pick();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return 8'h09;
      2: return CH_LF;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // never lets a CR LF pair end the line early
  function automatic void push_line_byte(input logic [7:0] b);
    if (frame_q.size() != 0 && frame_q[$] == CH_CR && b == CH_LF) b = CH_SPACE;
    frame_q.push_back(b);
  endfunction

  function automatic void build_size_line(input int unsigned size);
    int unsigned digits;
    int          i;
    logic [3:0]  nib;
    frame_q.delete();
    repeat ($urandom_range(2)) push_line_byte(ws_pick());
    repeat ($urandom_range(2)) frame_q.push_back("0");
    digits = 1;
    while (digits < 8 && (size >> (4 * digits)) != 0) digits++;
    for (i = digits - 1; i >= 0; i--) begin
      nib = 4'(size >> (4 * i));
      if (nib < 10) frame_q.push_back(8'("0" + nib));
      else if ($urandom_range(1)) frame_q.push_back(8'("a" + nib - 10));
      else frame_q.push_back(8'("A" + nib - 10));
    end
    repeat ($urandom_range(2)) push_line_byte(ws_pick());
    if ($urandom_range(2) == 0) begin
      frame_q.push_back(CH_SEMI);
      repeat ($urandom_range(6)) push_line_byte(8'($urandom_range(255)));
    end
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endfunction

  task automatic send_chunk(input int unsigned size, input bit detour, input bit good_trailer);
    logic [7:0] bad;
    build_size_line(size);
    repeat (size) frame_q.push_back(8'($urandom_range(255)));
    bad = 8'($urandom_range(255));
    if (good_trailer) begin
      frame_q.push_back(CH_CR);
      frame_q.push_back(CH_LF);
    end else if ($urandom_range(1)) begin
      frame_q.push_back(bad == CH_CR ? 8'h00 : bad);
    end else begin
      frame_q.push_back(CH_CR);
      frame_q.push_back(bad == CH_LF ? 8'h00 : bad);
    end
    send_frame(detour ? int'($urandom_range(frame_q.size() - 1)) : -1);
  endtask

  task automatic test_reset_passthrough();
    // enable resets to pass-through
    frame_q = '{8'h00, 8'hFF, CH_CR, CH_LF};
    send_frame(-1);
    drain_block();
    write_mode(1'b0);
    send_byte(8'h55);
    drain_block();
    write_mode(1'b1);
  endtask

  task automatic test_directed_chunks();
    // VT and FF around the digit, lone CR as whitespace, then a one-byte chunk;
    // lone LF, leading zero and an extension, then a two-byte chunk
    frame_q = '{8'h0B, "1", 8'h0C, CH_CR, CH_SPACE, CH_CR, CH_LF, 8'hFF, CH_CR, CH_LF,
                CH_LF, "0", "2", CH_SEMI, "z", CH_CR, CH_LF, 8'h00, 8'h80, CH_CR, CH_LF};
    send_frame(-1);
    drain_block();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold     = 300;
    send_chunk(64, 1'b0, 1'b1);
    drain_block();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned done_items;
    int unsigned pick;
    int unsigned size;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      done_items = items_sent - start;
      if (done_items < RANDOM_ITEMS / 3) begin
        src_idle_pct  = 6;
        sink_idle_pct = 62;
      end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 62;
        sink_idle_pct = 6;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        pick = $urandom_range(99);
        if (pick < 85) size = $urandom_range(1, 16);
        else if (pick < 98) size = $urandom_range(17, 80);
        else size = $urandom_range(200, 300);
        send_chunk(size, $urandom_range(9) == 0, 1'b1);
      end else begin
        detour_passthrough($urandom_range(1, 24));
      end
    end
    drain_block();
  endtask

  // a size line of exactly MAX_LINE bytes before its LF is still legal
  task automatic test_line_limit();
    frame_q = '{"1", CH_SEMI};
    repeat (MAX_LINE - 3) push_line_byte(8'($urandom_range(255)));
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
    frame_q.push_back(8'($urandom_range(255)));
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
    send_frame(-1);
    drain_block();
  endtask

  // one way to end the stream, then everything must be dropped in both modes
  task automatic test_stream_close();
    logic [7:0] bad;
    close_t     how;
    how = close_t'($urandom_range(5));
    case (how)
      CLOSE_END: build_size_line(0);
      CLOSE_OVERSIZE: build_size_line(MAX_CHUNK + 1 +
                                      ($urandom_range(1) ? 0 : $urandom_range(1 << 20)));
      CLOSE_LONG_LINE: begin
        frame_q = '{"1", CH_SEMI};
        repeat (MAX_LINE - 1) push_line_byte(8'($urandom_range(255)));
      end
      CLOSE_NO_DIGIT: begin
        frame_q.delete();
        repeat ($urandom_range(1, 3)) push_line_byte(ws_pick());
        if ($urandom_range(1)) begin
          frame_q.push_back(CH_SEMI);
          frame_q.push_back("q");
        end
        frame_q.push_back(CH_CR);
        frame_q.push_back(CH_LF);
      end
      CLOSE_BAD_CHAR: begin
        do bad = 8'($urandom_range(255));
        while ((bad >= "0" && bad <= "9") || (bad >= "a" && bad <= "f") ||
               (bad >= "A" && bad <= "F") || bad == CH_SEMI || bad == CH_SPACE ||
               (bad >= 8'h09 && bad <= 8'h0D));
        case ($urandom_range(2))
          0: frame_q = '{"0", "x", "1", "0", CH_CR, CH_LF};
          1: frame_q = '{"1", CH_SPACE, "2", CH_CR, CH_LF};
          default: frame_q = '{"1", bad, CH_CR, CH_LF};
        endcase
      end
      default: ;
    endcase
    if (how == CLOSE_BAD_TRAILER) send_chunk($urandom_range(1, 8), 1'b0, 1'b0);
    else send_frame(-1);
    repeat (16) send_byte(8'($urandom_range(255)));
    drain_block();
    write_mode(1'b0);
    repeat (16) send_byte(8'($urandom_range(255)));
    drain_block();
    write_mode(1'b1);
    repeat (8) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_passthrough();
    test_directed_chunks();
    test_backpressure();
    test_random_traffic();
    test_line_limit();
    test_stream_close();
    s_axis_tvalid <= 1'b0;
    for (n = 0; n < 5000 && pending_words.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule
